@@ rtl/mce_pkg.sv @@
// Shared types, constants, letter pattern ROM and microcode ROM for the Morse encoder.
`default_nettype none

package mce_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned PAT_W   = 16;
    localparam int unsigned UNITS_W = 3;

    localparam logic [CODE_W-1:0]  SPACE_CODE  = 8'd32;
    localparam logic [UNITS_W-1:0] BIT_UNITS   = 3'd1;
    localparam logic [UNITS_W-1:0] GAP_UNITS   = 3'd3;
    localparam logic [UNITS_W-1:0] SPACE_UNITS = 3'd4;

    // Sequencer steps; the step counter is the state of the sequencer.
    typedef enum logic [1:0] {
        ST_FETCH = 2'd0,
        ST_BITS  = 2'd1,
        ST_GAP   = 2'd2,
        ST_SPACE = 2'd3
    } t_step;

    // Jump conditions.
    typedef enum logic [1:0] {
        CND_ALWAYS = 2'd0,
        CND_SPACE  = 2'd1,
        CND_DONE   = 2'd2
    } t_cond;

    // When a step writes a result into the output register.
    typedef enum logic [1:0] {
        EM_NONE        = 2'd0,
        EM_ALWAYS      = 2'd1,
        EM_UNLESS_JUMP = 2'd2
    } t_emit;

    typedef struct packed {
        logic               wait_in;
        t_emit              emit;
        logic               level_from_pat;
        logic [UNITS_W-1:0] units;
        logic               last;
        logic               shift;
        t_cond              cond;
        t_step              target;
        t_step              fall;
    } t_uword;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic in_space;
        logic pat_done;
        logic out_blocked;
    } t_stat;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic take;
        logic load;
        logic emit;
        logic shift;
    } t_ctl;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{wait_in: 1'b0, emit: EM_NONE, level_from_pat: 1'b0, units: GAP_UNITS,
              last: 1'b0, shift: 1'b0, cond: CND_ALWAYS, target: ST_FETCH,
              fall: ST_FETCH};
        case (step)
            ST_FETCH: begin
                w.wait_in = 1'b1;
                w.cond    = CND_SPACE;
                w.target  = ST_SPACE;
                w.fall    = ST_BITS;
            end
            ST_BITS: begin
                w.emit           = EM_UNLESS_JUMP;
                w.level_from_pat = 1'b1;
                w.units          = BIT_UNITS;
                w.shift          = 1'b1;
                w.cond           = CND_DONE;
                w.target         = ST_GAP;
                w.fall           = ST_BITS;
            end
            ST_GAP: begin
                w.emit  = EM_ALWAYS;
                w.units = GAP_UNITS;
                w.last  = 1'b1;
            end
            ST_SPACE: begin
                w.emit  = EM_ALWAYS;
                w.units = SPACE_UNITS;
                w.last  = 1'b1;
            end
            default: begin
                w.cond = CND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    // Keying pattern of the letters A to Z; every other code has an empty pattern.
    function automatic logic [PAT_W-1:0] letter_pattern(input logic [CODE_W-1:0] code);
        logic [PAT_W-1:0] p;
        case (code)
            8'd65:   p = 16'd47104;
            8'd66:   p = 16'd60032;
            8'd67:   p = 16'd60320;
            8'd68:   p = 16'd59904;
            8'd69:   p = 16'd32768;
            8'd70:   p = 16'd44672;
            8'd71:   p = 16'd61056;
            8'd72:   p = 16'd43520;
            8'd73:   p = 16'd40960;
            8'd74:   p = 16'd48056;
            8'd75:   p = 16'd60288;
            8'd76:   p = 16'd47744;
            8'd77:   p = 16'd60928;
            8'd78:   p = 16'd59392;
            8'd79:   p = 16'd61152;
            8'd80:   p = 16'd48032;
            8'd81:   p = 16'd61112;
            8'd82:   p = 16'd47616;
            8'd83:   p = 16'd43008;
            8'd84:   p = 16'd57344;
            8'd85:   p = 16'd44544;
            8'd86:   p = 16'd43904;
            8'd87:   p = 16'd48000;
            8'd88:   p = 16'd60128;
            8'd89:   p = 16'd60344;
            8'd90:   p = 16'd61088;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mce_seq.sv @@
// Microcode sequencer: step counter, control word ROM and conditional jumps.
`default_nettype none

module mce_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mce_pkg::t_stat i_stat,
    output mce_pkg::t_uword     o_uword,
    output mce_pkg::t_ctl       o_ctl
);

    mce_pkg::t_step  r_step;
    mce_pkg::t_step  n_step;
    mce_pkg::t_uword uword;
    logic            cond_true;
    logic            emit;
    logic            fire;

    assign uword = mce_pkg::ucode(r_step);

    always_comb begin
        case (uword.cond)
            mce_pkg::CND_ALWAYS: cond_true = 1'b1;
            mce_pkg::CND_SPACE:  cond_true = i_stat.in_space;
            mce_pkg::CND_DONE:   cond_true = i_stat.pat_done;
            default:             cond_true = 1'b1;
        endcase
    end

    always_comb begin
        case (uword.emit)
            mce_pkg::EM_ALWAYS:      emit = 1'b1;
            mce_pkg::EM_UNLESS_JUMP: emit = !cond_true;
            default:                 emit = 1'b0;
        endcase
    end

    // A step waiting for input fires on a transfer; an emitting step waits for room.
    assign fire = uword.wait_in ? i_stat.in_valid : !(emit && i_stat.out_blocked);

    // Next state.
    always_comb begin
        n_step = r_step;
        if (fire) begin
            n_step = cond_true ? uword.target : uword.fall;
        end
    end

    // Outputs.
    always_comb begin
        o_uword     = uword;
        o_ctl.take  = uword.wait_in;
        o_ctl.load  = uword.wait_in && fire;
        o_ctl.emit  = emit && fire;
        o_ctl.shift = uword.shift && emit && fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mce_pkg::ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ rtl/morse_character_encoder_top.sv @@
// Top level of the Morse character encoder: pattern shifter, output register and sequencer.
`default_nettype none

// Takes one character code per input transfer and gives its Morse keying as a
// run of result transfers, each a line level and a length in time units. A
// letter A to Z gives one one-unit result per pattern bit and then a closing
// low gap of 3 units; a space gives a single low run of 4 units; any other
// code gives only the 3-unit gap. The last result of a character carries
// run_end. A small microcoded sequencer steps through the work, one step per
// cycle when the output side keeps up: a letter runs fetch, a bit step per
// pattern bit, a bit step that finds the pattern done, and gap; a space
// runs fetch and space; other codes run fetch, that bit step and gap. A
// single output register holds the waiting result, and the sequencer stalls
// while it is full and not being taken. The next character is taken once
// the previous one's last result has been written into that register.
module morse_character_encoder_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [mce_pkg::CODE_W-1:0]   i_char_code,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_line_level,
    output logic [mce_pkg::UNITS_W-1:0]       o_unit_count,
    output logic                              o_run_end
);

    mce_pkg::t_stat              stat;
    mce_pkg::t_ctl               ctl;
    mce_pkg::t_uword             uword;
    logic [mce_pkg::PAT_W-1:0]   r_pat;
    logic                        r_out_valid;
    logic                        r_level;
    logic [mce_pkg::UNITS_W-1:0] r_units;
    logic                        r_last;

    assign stat.in_valid    = i_valid;
    assign stat.in_space    = (i_char_code == mce_pkg::SPACE_CODE);
    assign stat.pat_done    = (r_pat[mce_pkg::PAT_W-1 -: 2] == 2'b00);
    assign stat.out_blocked = r_out_valid && !i_ready;

    mce_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword),
        .o_ctl   (ctl)
    );

    // The pattern is sent from its top bit, one bit per emitted unit.
    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_pat <= mce_pkg::letter_pattern(i_char_code);
        end else if (ctl.shift) begin
            r_pat <= {r_pat[mce_pkg::PAT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_level <= uword.level_from_pat && r_pat[mce_pkg::PAT_W-1];
            r_units <= uword.units;
            r_last  <= uword.last;
        end
    end

    assign o_ready      = ctl.take;
    assign o_valid      = r_out_valid;
    assign o_line_level = r_level;
    assign o_unit_count = r_units;
    assign o_run_end    = r_last;

endmodule

`default_nettype wire
